// ===== hw/rtl/gsmm_pkg.sv =====
// Shared types and constants for the grid store with minimum marking.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package gsmm_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned VALUE_W  = 25;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned ADDS_W   = 16;
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned APB_DW   = 32;

  localparam logic [COUNT_W-1:0] MAX_MARKS = 7'd64;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_MARK = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_NONE_LEFT = 2'd2,
    STAT_UNUSED    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_X_LOW  = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_Y_LOW  = 3'd2,
    REG_Y_HIGH = 3'd3,
    REG_Z_LOW  = 3'd4,
    REG_Z_HIGH = 3'd5,
    REG_SPARE6 = 3'd6,
    REG_SPARE7 = 3'd7
  } reg_e;

  // one stored grid cell
  typedef struct packed {
    logic                       marked;
    logic signed [VALUE_W-1:0]  value;
  } cell_t;

  // one result item
  typedef struct packed {
    status_e                    status;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic signed [VALUE_W-1:0]  value;
    logic                       marked;
    logic [ADDS_W-1:0]          add_count;
    logic                       last;
  } result_t;

  // per-axis bounds check results
  typedef struct packed {
    logic in_range;
    logic empty;
  } axis_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gsmm_axis.sv =====
// Bounds check for one grid axis: coordinate offset, range and empty flags and last scan index.
// Depends on gsmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsmm_axis
  import gsmm_pkg::*;
#(
  parameter int unsigned CELLS = 16
) (
  input  wire logic signed [COORD_W-1:0] coord_i,
  input  wire logic signed [COORD_W-1:0] low_i,
  input  wire logic signed [COORD_W-1:0] high_i,
  output axis_flags_t                    flags_o,
  output logic [((CELLS > 1) ? $clog2(CELLS) : 1)-1:0] index_o,
  output logic [((CELLS > 1) ? $clog2(CELLS) : 1)-1:0] last_o
);

  localparam int unsigned IW = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic signed [COORD_W:0] off;
  logic signed [COORD_W:0] span;

  assign off  = {coord_i[COORD_W-1], coord_i} - {low_i[COORD_W-1], low_i};
  assign span = {high_i[COORD_W-1], high_i} - {low_i[COORD_W-1], low_i};

  assign flags_o.in_range = !off[COORD_W] && (coord_i <= high_i) &&
                            (off < $signed((COORD_W+1)'(CELLS)));
  assign flags_o.empty    = span[COORD_W];
  assign index_o          = off[IW-1:0];

  // last usable offset, clipped to the number of cells on this axis
  always_comb begin
    if (span >= $signed((COORD_W+1)'(CELLS - 1))) begin
      last_o = IW'(CELLS - 1);
    end else begin
      last_o = span[IW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gsmm_store.sv =====
// Cell memory of the grid store with a clearing sweep after reset.
// Depends on gsmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsmm_store
  import gsmm_pkg::*;
#(
  parameter int unsigned AW = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire cell_t         wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output cell_t              rdata_o,
  output logic               ready_o
);

  localparam int unsigned DEPTH = 1 << AW;

  cell_t       mem_q [DEPTH];
  cell_t       rdata_q;
  logic        clearing_q;
  logic [AW-1:0] clr_addr_q;
  logic        wen;
  logic [AW-1:0] waddr;
  cell_t       wdata;

  always_comb begin
    if (clearing_q) begin
      wen         = 1'b1;
      waddr       = clr_addr_q;
      wdata.marked = 1'b0;
      wdata.value  = '1;
    end else begin
      wen   = we_i;
      waddr = waddr_i;
      wdata = wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clearing_q;

endmodule

`default_nettype wire

// ===== hw/rtl/grid_store_with_min_marking_top.sv =====
// Top level of the grid store with minimum marking: sequencer, compare unit and ports.
// Depends on gsmm_pkg, gsmm_axis and gsmm_store.
`timescale 1ns / 1ps
`default_nettype none

// Grid store with minimum marking. After reset the block sweeps its cell memory once,
// one cell per cycle over all 2^(XW+YW+ZW) cells (4096 at the default 16x16x16 grid, XW
// being the index width of an axis), and takes no request until the sweep is done;
// configuration writes are taken all the time. An in-range add or read request goes from
// acceptance through the decode, access and emit states to a result in the output
// register. A mark request walks every cell of the configured region once per minimum
// found, one memory read per cycle through a single compare unit, then passes the
// drain, done and emit states for each marked entry. The input side accepts a new
// request while the last result still waits in the output register.
module grid_store_with_min_marking_top
  import gsmm_pkg::*;
#(
  parameter int unsigned X_CELLS = 16,
  parameter int unsigned Y_CELLS = 16,
  parameter int unsigned Z_CELLS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // tdata: coord_x[15:0], coord_y[31:16], coord_z[47:32], value_in[72:48],
  //        mark_count[79:73]
  input  wire logic [79:0]       s_axis_tdata_i,
  // tuser: action[1:0]
  input  wire logic [1:0]        s_axis_tuser_i,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: entry_x[15:0], entry_y[31:16], entry_z[47:32], entry_value[72:48],
  //        entry_marked[73], add_count[89:74], zero fill [95:90]
  output logic [95:0]            m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [1:0]             m_axis_tuser_o,
  output logic                   m_axis_tlast_o,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int unsigned XW = (X_CELLS > 1) ? $clog2(X_CELLS) : 1;
  localparam int unsigned YW = (Y_CELLS > 1) ? $clog2(Y_CELLS) : 1;
  localparam int unsigned ZW = (Z_CELLS > 1) ? $clog2(Z_CELLS) : 1;
  localparam int unsigned AW = XW + YW + ZW;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_DECODE = 8'b0000_0100,
    ST_ACCESS = 8'b0000_1000,
    ST_SCAN   = 8'b0001_0000,
    ST_DRAIN  = 8'b0010_0000,
    ST_DONE   = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic signed [COORD_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q, z_low_q, z_high_q;
  logic                      cfg_we;

  // captured request
  action_e                   act_q;
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic signed [VALUE_W-1:0] val_q;
  logic [COUNT_W-1:0]        cnt_q;

  // scan sequencer and compare unit
  logic [XW-1:0]             ix_q, s1_x_q, best_x_q;
  logic [YW-1:0]             iy_q, s1_y_q, best_y_q;
  logic [ZW-1:0]             iz_q, s1_z_q, best_z_q;
  logic                      s1_valid_q;
  logic                      found_q;
  logic signed [VALUE_W-1:0] best_q;
  logic [COUNT_W-1:0]        rem_q;
  logic                      more_q;
  logic                      scan_init;
  logic                      scan_end;

  logic [ADDS_W-1:0]         adds_q;
  result_t                   res_q, out_q;
  logic                      m_valid_q;
  logic                      out_free;

  // axis checks
  axis_flags_t               fx, fy, fz;
  logic [XW-1:0]             offx, lastx;
  logic [YW-1:0]             offy, lasty;
  logic [ZW-1:0]             offz, lastz;
  logic                      in_range;
  logic                      region_empty;

  // memory port
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  cell_t                     mem_wdata, mem_rdata;
  logic                      mem_ready;

  logic signed [VALUE_W-1:0] clamped;
  logic [ADDS_W-1:0]         adds_inc;
  logic                      accept;

  gsmm_axis #(.CELLS(X_CELLS)) u_axis_x (
    .coord_i(cx_q), .low_i(x_low_q), .high_i(x_high_q),
    .flags_o(fx), .index_o(offx), .last_o(lastx)
  );

  gsmm_axis #(.CELLS(Y_CELLS)) u_axis_y (
    .coord_i(cy_q), .low_i(y_low_q), .high_i(y_high_q),
    .flags_o(fy), .index_o(offy), .last_o(lasty)
  );

  gsmm_axis #(.CELLS(Z_CELLS)) u_axis_z (
    .coord_i(cz_q), .low_i(z_low_q), .high_i(z_high_q),
    .flags_o(fz), .index_o(offz), .last_o(lastz)
  );

  gsmm_store #(.AW(AW)) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata),
    .ready_o(mem_ready)
  );

  assign in_range     = fx.in_range && fy.in_range && fz.in_range;
  assign region_empty = fx.empty || fy.empty || fz.empty;
  assign scan_end     = (ix_q == lastx) && (iy_q == lasty) && (iz_q == lastz);
  assign out_free     = !m_valid_q || m_axis_tready_i;
  assign accept       = s_axis_tvalid_i && s_axis_tready_o;

  // anything below minus one is stored as minus one
  assign clamped  = (val_q[VALUE_W-1] && (val_q != '1)) ? '1 : val_q;
  assign adds_inc = (adds_q == '1) ? adds_q : adds_q + 1'b1;

  assign mem_raddr = (state_q == ST_SCAN) ? {ix_q, iy_q, iz_q} : {offx, offy, offz};

  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = {offx, offy, offz};
    mem_wdata.marked = mem_rdata.marked;
    mem_wdata.value  = clamped;
    if (state_q == ST_ACCESS && act_q == ACT_ADD) begin
      mem_we = 1'b1;
    end else if (state_q == ST_DONE && found_q) begin
      mem_we           = 1'b1;
      mem_waddr        = {best_x_q, best_y_q, best_z_q};
      mem_wdata.marked = 1'b1;
      mem_wdata.value  = best_q;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    scan_init = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (mem_ready) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (act_q)
          ACT_ADD, ACT_READ: begin
            state_d = in_range ? ST_ACCESS : ST_EMIT;
          end
          ACT_MARK: begin
            if (cnt_q == '0) begin
              state_d = ST_IDLE;
            end else if (region_empty) begin
              state_d = ST_EMIT;
            end else begin
              state_d   = ST_SCAN;
              scan_init = 1'b1;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_ACCESS: state_d = ST_EMIT;
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (more_q) begin
            state_d   = ST_SCAN;
            scan_init = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      adds_q     <= '0;
      m_valid_q  <= 1'b0;
      s1_valid_q <= 1'b0;
      found_q    <= 1'b0;
      more_q     <= 1'b0;
      rem_q      <= '0;
      ix_q       <= '0;
      iy_q       <= '0;
      iz_q       <= '0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= (state_q == ST_SCAN);

      if (state_q == ST_EMIT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      if (state_q == ST_ACCESS && act_q == ACT_ADD) begin
        adds_q <= adds_inc;
      end

      if (state_q == ST_DECODE) begin
        rem_q  <= (cnt_q > MAX_MARKS) ? MAX_MARKS : cnt_q;
        more_q <= 1'b0;
      end else if (state_q == ST_DONE && found_q) begin
        rem_q  <= rem_q - 1'b1;
        more_q <= (rem_q != COUNT_W'(1));
      end else if (state_q == ST_DONE) begin
        more_q <= 1'b0;
      end

      // scan counters walk z fastest, then y, then x
      if (scan_init) begin
        ix_q <= '0;
        iy_q <= '0;
        iz_q <= '0;
      end else if (state_q == ST_SCAN) begin
        if (iz_q != lastz) begin
          iz_q <= iz_q + 1'b1;
        end else begin
          iz_q <= '0;
          if (iy_q != lasty) begin
            iy_q <= iy_q + 1'b1;
          end else begin
            iy_q <= '0;
            ix_q <= ix_q + 1'b1;
          end
        end
      end

      // compare unit: strict less keeps the first cell in scan order on a tie
      if (scan_init) begin
        found_q <= 1'b0;
      end else if (s1_valid_q && !mem_rdata.marked &&
                   (!found_q || ($signed(mem_rdata.value) < best_q))) begin
        found_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_e'(s_axis_tuser_i);
      cx_q  <= s_axis_tdata_i[15:0];
      cy_q  <= s_axis_tdata_i[31:16];
      cz_q  <= s_axis_tdata_i[47:32];
      val_q <= s_axis_tdata_i[72:48];
      cnt_q <= s_axis_tdata_i[79:73];
    end

    s1_x_q <= ix_q;
    s1_y_q <= iy_q;
    s1_z_q <= iz_q;

    if (s1_valid_q && !mem_rdata.marked &&
        (!found_q || ($signed(mem_rdata.value) < best_q))) begin
      best_q   <= mem_rdata.value;
      best_x_q <= s1_x_q;
      best_y_q <= s1_y_q;
      best_z_q <= s1_z_q;
    end

    if (state_q == ST_EMIT && out_free) begin
      out_q <= res_q;
    end

    case (state_q)
      ST_DECODE: begin
        res_q.add_count <= adds_q;
        res_q.last      <= 1'b1;
        res_q.value     <= '0;
        res_q.marked    <= 1'b0;
        if (act_q == ACT_MARK) begin
          res_q.status <= STAT_NONE_LEFT;
          res_q.x      <= '0;
          res_q.y      <= '0;
          res_q.z      <= '0;
        end else begin
          res_q.status <= STAT_RANGE;
          res_q.x      <= cx_q;
          res_q.y      <= cy_q;
          res_q.z      <= cz_q;
        end
      end
      ST_ACCESS: begin
        res_q.status <= STAT_OK;
        res_q.marked <= mem_rdata.marked;
        if (act_q == ACT_ADD) begin
          res_q.value     <= clamped;
          res_q.add_count <= adds_inc;
        end else begin
          res_q.value     <= mem_rdata.value;
          res_q.add_count <= adds_q;
        end
      end
      ST_DONE: begin
        res_q.add_count <= adds_q;
        if (found_q) begin
          res_q.status <= STAT_OK;
          res_q.x      <= x_low_q + COORD_W'(best_x_q);
          res_q.y      <= y_low_q + COORD_W'(best_y_q);
          res_q.z      <= z_low_q + COORD_W'(best_z_q);
          res_q.value  <= best_q;
          res_q.marked <= 1'b1;
          res_q.last   <= (rem_q == COUNT_W'(1));
        end else begin
          res_q.status <= STAT_NONE_LEFT;
          res_q.x      <= '0;
          res_q.y      <= '0;
          res_q.z      <= '0;
          res_q.value  <= '0;
          res_q.marked <= 1'b0;
          res_q.last   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // configuration registers
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q  <= 16'sd0;
      x_high_q <= 16'sd15;
      y_low_q  <= 16'sd0;
      y_high_q <= 16'sd15;
      z_low_q  <= 16'sd0;
      z_high_q <= 16'sd15;
    end else if (cfg_we) begin
      case (reg_e'(paddr[4:2]))
        REG_X_LOW:  x_low_q  <= pwdata[COORD_W-1:0];
        REG_X_HIGH: x_high_q <= pwdata[COORD_W-1:0];
        REG_Y_LOW:  y_low_q  <= pwdata[COORD_W-1:0];
        REG_Y_HIGH: y_high_q <= pwdata[COORD_W-1:0];
        REG_Z_LOW:  z_low_q  <= pwdata[COORD_W-1:0];
        REG_Z_HIGH: z_high_q <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[4:2]))
      REG_X_LOW:  prdata = APB_DW'(x_low_q);
      REG_X_HIGH: prdata = APB_DW'(x_high_q);
      REG_Y_LOW:  prdata = APB_DW'(y_low_q);
      REG_Y_HIGH: prdata = APB_DW'(y_high_q);
      REG_Z_LOW:  prdata = APB_DW'(z_low_q);
      REG_Z_HIGH: prdata = APB_DW'(z_high_q);
      default:    prdata = '0;
    endcase
  end

  // ports
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {6'b0, out_q.add_count, out_q.marked, out_q.value,
                            out_q.z, out_q.y, out_q.x};

endmodule

`default_nettype wire

// ===== test/grid_store_with_min_marking_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for grid_store_with_min_marking_top: a shadow grid predicts every
// entry report while a stream driver and monitor run under random idling and stalls.
// Depends on gsmm_pkg and the RTL of the block.

module grid_store_with_min_marking_top_test;
  import gsmm_pkg::*;

  localparam int X_CELLS          = 16;
  localparam int Y_CELLS          = 16;
  localparam int Z_CELLS          = 16;
  localparam int GRID_CELLS       = X_CELLS * Y_CELLS * Z_CELLS;
  // slowest step: one full-grid mark pass, or the clearing sweep
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int SETTLE_CYCLES    = 64;
  localparam int SHOWN_MISMATCHES = 100;

  typedef struct {
    action_e                   act;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic signed [VALUE_W-1:0] val;
    logic [COUNT_W-1:0]        cnt;
  } grid_req_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic [79:0]       s_axis_tdata_i  = '0;
  logic [1:0]        s_axis_tuser_i  = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [95:0]       m_axis_tdata_o;
  logic [1:0]        m_axis_tuser_o;
  logic              m_axis_tlast_o;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [APB_AW-1:0] paddr           = '0;
  logic [APB_DW-1:0] pwdata          = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // shadow copy of the grid and the bound registers
  logic signed [VALUE_W-1:0] shadow_value [GRID_CELLS];
  logic                      shadow_mark  [GRID_CELLS];
  logic [ADDS_W-1:0]         shadow_adds;
  int                        lo_bound   [3];
  int                        hi_bound   [3];
  int                        axis_cells [3] = '{X_CELLS, Y_CELLS, Z_CELLS};

  grid_req_t request_backlog  [$];
  result_t   entry_reports_due[$];
  grid_req_t on_bus;
  int        send_gap_pct;
  int        recv_stall_pct;
  int        mismatches   = 0;
  int        reports_seen = 0;
  int        quiet_cycles = 0;

  grid_store_with_min_marking_top #(
    .X_CELLS(X_CELLS),
    .Y_CELLS(Y_CELLS),
    .Z_CELLS(Z_CELLS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string field, input longint got, input longint want);
    if (mismatches < SHOWN_MISMATCHES) begin
      $display("%0t: mismatch in %s after %0d reports: got %0d, want %0d",
               $time, field, reports_seen, got, want);
    end
    mismatches++;
  endtask

  // usable cells along one axis under the current bounds
  function automatic int axis_span(int axis);
    int n;
    if (hi_bound[axis] < lo_bound[axis]) return 0;
    n = hi_bound[axis] - lo_bound[axis] + 1;
    return (n > axis_cells[axis]) ? axis_cells[axis] : n;
  endfunction

  function automatic bit locate_cell(input int x, input int y, input int z, output int idx);
    int ox, oy, oz;
    ox  = x - lo_bound[0];
    oy  = y - lo_bound[1];
    oz  = z - lo_bound[2];
    idx = 0;
    if (ox < 0 || oy < 0 || oz < 0) return 1'b0;
    if (ox >= axis_span(0) || oy >= axis_span(1) || oz >= axis_span(2)) return 1'b0;
    idx = (ox * Y_CELLS + oy) * Z_CELLS + oz;
    return 1'b1;
  endfunction

  function automatic result_t entry_report(status_e st, int x, int y, int z, int v,
                                           logic mk, logic lst);
    result_t r;
    r.status    = st;
    r.x         = COORD_W'(x);
    r.y         = COORD_W'(y);
    r.z         = COORD_W'(z);
    r.value     = VALUE_W'(v);
    r.marked    = mk;
    r.add_count = shadow_adds;
    r.last      = lst;
    return r;
  endfunction

  // applies one accepted request to the shadow grid and queues the reports it causes
  task automatic model_grid_action(input grid_req_t q);
    int   idx, v, k, marks, c, best, bidx, bx, by, bz;
    logic found;
    case (q.act)
      ACT_ADD, ACT_READ: begin
        if (!locate_cell(q.cx, q.cy, q.cz, idx)) begin
          entry_reports_due.push_back(entry_report(STAT_RANGE, q.cx, q.cy, q.cz, 0, 1'b0, 1'b1));
        end else begin
          if (q.act == ACT_ADD) begin
            v = q.val;
            if (v < -1) v = -1;
            shadow_value[idx] = VALUE_W'(v);
            if (shadow_adds != '1) shadow_adds++;
          end
          entry_reports_due.push_back(entry_report(STAT_OK, q.cx, q.cy, q.cz,
                                                   shadow_value[idx], shadow_mark[idx], 1'b1));
        end
      end
      ACT_MARK: begin
        marks = (q.cnt > MAX_MARKS) ? int'(MAX_MARKS) : int'(q.cnt);
        for (k = 0; k < marks; k++) begin
          found = 1'b0;
          best  = 0;
          bidx  = 0;
          bx    = 0;
          by    = 0;
          bz    = 0;
          for (int ix = 0; ix < axis_span(0); ix++) begin
            for (int iy = 0; iy < axis_span(1); iy++) begin
              for (int iz = 0; iz < axis_span(2); iz++) begin
                c = (ix * Y_CELLS + iy) * Z_CELLS + iz;
                // strict compare keeps the first cell in scan order on a tie
                if (!shadow_mark[c] && (!found || shadow_value[c] < best)) begin
                  found = 1'b1;
                  best  = shadow_value[c];
                  bidx  = c;
                  bx    = ix;
                  by    = iy;
                  bz    = iz;
                end
              end
            end
          end
          if (!found) begin
            entry_reports_due.push_back(entry_report(STAT_NONE_LEFT, 0, 0, 0, 0, 1'b0, 1'b1));
            break;
          end
          shadow_mark[bidx] = 1'b1;
          entry_reports_due.push_back(entry_report(STAT_OK, lo_bound[0] + bx, lo_bound[1] + by,
                                                   lo_bound[2] + bz, best, 1'b1,
                                                   (k + 1 == marks)));
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_entry_report();
    result_t want;
    reports_seen++;
    if (entry_reports_due.size() == 0) begin
      report_mismatch("unexpected report, status", m_axis_tuser_o, 0);
      return;
    end
    want = entry_reports_due.pop_front();
    if (m_axis_tuser_o !== want.status)
      report_mismatch("status", m_axis_tuser_o, want.status);
    if (m_axis_tdata_o[15:0] !== want.x)
      report_mismatch("entry_x", $signed(m_axis_tdata_o[15:0]), want.x);
    if (m_axis_tdata_o[31:16] !== want.y)
      report_mismatch("entry_y", $signed(m_axis_tdata_o[31:16]), want.y);
    if (m_axis_tdata_o[47:32] !== want.z)
      report_mismatch("entry_z", $signed(m_axis_tdata_o[47:32]), want.z);
    if (m_axis_tdata_o[72:48] !== want.value)
      report_mismatch("entry_value", $signed(m_axis_tdata_o[72:48]), want.value);
    if (m_axis_tdata_o[73] !== want.marked)
      report_mismatch("entry_marked", m_axis_tdata_o[73], want.marked);
    if (m_axis_tdata_o[89:74] !== want.add_count)
      report_mismatch("add_count", m_axis_tdata_o[89:74], want.add_count);
    if (m_axis_tdata_o[95:90] !== '0)
      report_mismatch("tdata fill", m_axis_tdata_o[95:90], 0);
    if (m_axis_tlast_o !== want.last)
      report_mismatch("last", m_axis_tlast_o, want.last);
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) model_grid_action(on_bus);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          on_bus = request_backlog.pop_front();
          s_axis_tdata_i  <= {on_bus.cnt, on_bus.val, on_bus.cz, on_bus.cy, on_bus.cx};
          s_axis_tuser_i  <= on_bus.act;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // report monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_entry_report();
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // register write through setup and access, then read back
  task automatic write_bound(input reg_e r, input int v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(r) * 4);
    pwdata  <= APB_DW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (r[0]) hi_bound[int'(r) >> 1] = int'($signed(16'(v)));
    else lo_bound[int'(r) >> 1] = int'($signed(16'(v)));
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== 16'(v)) report_mismatch("register readback", prdata[15:0], 16'(v));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_bounds(input int xl, input int xh, input int yl, input int yh,
                             input int zl, input int zh);
    write_bound(REG_X_LOW, xl);
    write_bound(REG_X_HIGH, xh);
    write_bound(REG_Y_LOW, yl);
    write_bound(REG_Y_HIGH, yh);
    write_bound(REG_Z_LOW, zl);
    write_bound(REG_Z_HIGH, zh);
  endtask

  // wait until every request is taken and every report is in, then let the block go quiet
  task automatic settle();
    do @(negedge clk_i);
    while (request_backlog.size() != 0 || s_axis_tvalid_i || entry_reports_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic grid_req_t grid_request(action_e a, int x, int y, int z, int v, int n);
    grid_req_t q;
    q.act = a;
    q.cx  = COORD_W'(x);
    q.cy  = COORD_W'(y);
    q.cz  = COORD_W'(z);
    q.val = VALUE_W'(v);
    q.cnt = COUNT_W'(n);
    return q;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(int axis);
    int span;
    span = axis_span(axis);
    if (span == 0) return COORD_W'($urandom);
    return COORD_W'(lo_bound[axis] + int'($urandom_range(span - 1)));
  endfunction

  // mostly in-range adds, reads and small marks; the rest is noise
  function automatic grid_req_t random_request();
    grid_req_t q;
    int        pick;
    pick  = $urandom_range(99);
    q.cx  = COORD_W'($urandom);
    q.cy  = COORD_W'($urandom);
    q.cz  = COORD_W'($urandom);
    q.cnt = COUNT_W'($urandom);
    case ($urandom_range(9))
      0:       q.val = '1;
      1, 2:    q.val = VALUE_W'($urandom);
      default: q.val = VALUE_W'($urandom_range(24'hFFFFFF));
    endcase
    if (pick < 65) begin
      q.act = (pick < 40) ? ACT_ADD : ACT_READ;
      q.cx  = pick_coord(0);
      q.cy  = pick_coord(1);
      q.cz  = pick_coord(2);
    end else if (pick < 80) begin
      q.act = ACT_MARK;
      if ($urandom_range(9) != 0) q.cnt = COUNT_W'($urandom_range(4, 1));
    end else if (pick < 95) begin
      q.act = ($urandom_range(1) != 0) ? ACT_ADD : ACT_READ;
    end else begin
      q.act = ACT_NONE;
    end
    return q;
  endfunction

  task automatic queue_random(input int n);
    repeat (n) request_backlog.push_back(random_request());
  endtask

  initial begin
    for (int i = 0; i < GRID_CELLS; i++) begin
      shadow_value[i] = '1;
      shadow_mark[i]  = 1'b0;
    end
    shadow_adds    = '0;
    lo_bound       = '{0, 0, 0};
    hi_bound       = '{15, 15, 15};
    send_gap_pct   = 12;
    recv_stall_pct = 65;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset bounds: field extremes, range errors, marks, ignored action
    request_backlog.push_back(grid_request(ACT_READ, 0, 0, 0, 0, 0));
    request_backlog.push_back(grid_request(ACT_ADD, 0, 0, 0, 24'hFFFFFF, 127));
    request_backlog.push_back(grid_request(ACT_ADD, 15, 15, 15, -1, 0));
    request_backlog.push_back(grid_request(ACT_ADD, 15, 0, 7, -16777216, 0));
    request_backlog.push_back(grid_request(ACT_ADD, 3, 4, 5, 0, 0));
    request_backlog.push_back(grid_request(ACT_ADD, 16, 0, 0, 7, 0));
    request_backlog.push_back(grid_request(ACT_ADD, -1, 0, 0, 7, 0));
    request_backlog.push_back(grid_request(ACT_ADD, 0, -32768, 0, 7, 0));
    request_backlog.push_back(grid_request(ACT_READ, 0, 0, 32767, 0, 0));
    request_backlog.push_back(grid_request(ACT_READ, 32767, -32768, 32767, 0, 0));
    request_backlog.push_back(grid_request(ACT_READ, 15, 15, 15, 0, 0));
    request_backlog.push_back(grid_request(ACT_READ, 15, 0, 7, 0, 0));
    request_backlog.push_back(grid_request(ACT_NONE, -1, -1, -1, -1, 127));
    request_backlog.push_back(grid_request(ACT_MARK, 0, 0, 0, 0, 0));
    request_backlog.push_back(grid_request(ACT_MARK, 0, 0, 0, 0, 1));
    request_backlog.push_back(grid_request(ACT_MARK, -1, -1, -1, -1, 2));
    request_backlog.push_back(grid_request(ACT_READ, 0, 0, 1, 0, 0));
    request_backlog.push_back(grid_request(ACT_ADD, 0, 0, 1, 5, 0));
    request_backlog.push_back(grid_request(ACT_READ, 3, 4, 5, 0, 0));
    settle();

    // small region with negative lows; stored cells keep their offsets
    load_bounds(-2, 1, 5, 7, -32768, -32766);
    queue_random(35);
    settle();

    send_gap_pct   = 65;
    recv_stall_pct = 12;
    // register extremes: x capped by the cell count, single y plane
    load_bounds(-32768, 32767, 32767, 32767, 32760, 32767);
    request_backlog.push_back(grid_request(ACT_ADD, -32753, 32767, 32767, 1, 0));
    request_backlog.push_back(grid_request(ACT_ADD, -32752, 32767, 32767, 1, 0));
    request_backlog.push_back(grid_request(ACT_READ, -32768, 32767, 32760, 0, 0));
    request_backlog.push_back(grid_request(ACT_MARK, 0, 0, 0, 0, 127));
    queue_random(35);
    settle();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    // inverted y bounds: nothing is in range
    load_bounds(0, 15, 5, 4, 0, 15);
    request_backlog.push_back(grid_request(ACT_MARK, 0, 0, 0, 0, 3));
    request_backlog.push_back(grid_request(ACT_ADD, 0, 5, 0, 9, 0));
    queue_random(10);
    settle();

    // eight cells, so marks run out
    load_bounds(14, 15, 0, 1, 15, 16);
    request_backlog.push_back(grid_request(ACT_MARK, 0, 0, 0, 0, 100));
    request_backlog.push_back(grid_request(ACT_MARK, 0, 0, 0, 0, 1));
    queue_random(30);
    settle();

    if (mismatches == 0 && entry_reports_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
